### rtl/modbus_rtu_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// Modbus RTU frame receiver: assertion macros
// Shared assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_FRAME_RECEIVER_DEFINES_SVH
`define MODBUS_RTU_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication
`define MBRTU_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("mbrtu assertion failed");

// next-cycle implication
`define MBRTU_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("mbrtu assertion failed");

`endif

### rtl/mbrtu_pkg.sv
// ----------------------------------------------------------------------------
// Modbus RTU frame receiver package
// Codes, widths and item types shared by the block.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  localparam int COUNT_W = 9;
  localparam int INDEX_W = 8;
  localparam int GAP_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] FRAME_BYTES = 9'd256;

  // actions
  localparam logic [2:0] ACT_BYTE  = 3'd0;
  localparam logic [2:0] ACT_TICK  = 3'd1;
  localparam logic [2:0] ACT_CHECK = 3'd2;
  localparam logic [2:0] ACT_SEND  = 3'd3;
  localparam logic [2:0] ACT_SENT  = 3'd4;

  // link states
  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RECV  = 3'd2;
  localparam logic [2:0] ST_GAP   = 3'd3;
  localparam logic [2:0] ST_READY = 3'd4;
  localparam logic [2:0] ST_ERR   = 3'd5;
  localparam logic [2:0] ST_BAD   = 3'd6;
  localparam logic [2:0] ST_SEND  = 3'd7;

  // frame check results
  localparam logic [1:0] RES_NONE = 2'd0;
  localparam logic [1:0] RES_GOOD = 2'd1;
  localparam logic [1:0] RES_BAD  = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_GAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_GAP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_GAP  = 2'd2;

  localparam logic [GAP_W-1:0] SHORT_GAP_RST = 16'd750;
  localparam logic [GAP_W-1:0] REST_GAP_RST  = 16'd1000;
  localparam logic [GAP_W-1:0] LONG_GAP_RST  = 16'd1750;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic [2:0]         action;
    logic [7:0]         rx_data;
    logic [COUNT_W-1:0] send_length;
  } item_t;

  typedef struct packed {
    logic [2:0]         link_state;
    logic               store_valid;
    logic [INDEX_W-1:0] store_index;
    logic [1:0]         frame_result;
    logic [COUNT_W-1:0] frame_length;
    logic               send_accepted;
    logic               send_valid;
    logic [INDEX_W-1:0] send_index;
    logic               tx_enable;
  } result_t;

endpackage

### rtl/mbrtu_if.sv
// ----------------------------------------------------------------------------
// Modbus RTU frame receiver channels
// Command and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mbrtu_cmd_if;
  import mbrtu_pkg::*;

  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [7:0]         rx_data;
  logic [COUNT_W-1:0] send_length;

  modport source (output valid, action, rx_data, send_length, input ready);
  modport sink   (input valid, action, rx_data, send_length, output ready);
endinterface

interface mbrtu_res_if;
  import mbrtu_pkg::*;

  logic               valid;
  logic               ready;
  logic [2:0]         link_state;
  logic               store_valid;
  logic [INDEX_W-1:0] store_index;
  logic [1:0]         frame_result;
  logic [COUNT_W-1:0] frame_length;
  logic               send_accepted;
  logic               send_valid;
  logic [INDEX_W-1:0] send_index;
  logic               tx_enable;

  modport source (output valid, link_state, store_valid, store_index, frame_result,
                  frame_length, send_accepted, send_valid, send_index, tx_enable,
                  input ready);
  modport sink   (input valid, link_state, store_valid, store_index, frame_result,
                  frame_length, send_accepted, send_valid, send_index, tx_enable,
                  output ready);
endinterface

### rtl/mbrtu_crc.sv
// ----------------------------------------------------------------------------
// Modbus RTU CRC byte update
// One byte of CRC-16/MODBUS, reflected, eight shift steps.
// ----------------------------------------------------------------------------
module mbrtu_crc (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);
  import mbrtu_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end
endmodule

### rtl/mbrtu_core.sv
// ----------------------------------------------------------------------------
// Modbus RTU link core
// Link state, silence timer, running CRC history and transmit counters.
// ----------------------------------------------------------------------------
module mbrtu_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mbrtu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbrtu_pkg::GAP_W-1:0]         cfg_data,
  input  logic                                fire,
  input  mbrtu_pkg::item_t                    item,
  output mbrtu_pkg::result_t                  result
);
  import mbrtu_pkg::*;

  logic [GAP_W-1:0]   short_gap, rest_gap, long_gap;
  logic [2:0]         link_mode, link_mode_next;
  logic [GAP_W-1:0]   gap_count, gap_count_next;
  logic               gap_running, gap_running_next;
  logic [COUNT_W-1:0] rx_count, rx_count_next;
  logic [15:0]        crc_all, crc_all_next;
  logic [15:0]        crc_less_one, crc_less_one_next;
  logic [15:0]        crc_less_two, crc_less_two_next;
  logic [15:0]        last_two_bytes, last_two_bytes_next;
  logic [COUNT_W-1:0] tx_total, tx_total_next;
  logic [COUNT_W-1:0] tx_sent, tx_sent_next;
  logic               tx_on, tx_on_next;

  logic [15:0]        crc_seed, crc_new;
  logic [COUNT_W-1:0] slen, sent_inc;

  assign crc_seed = (link_mode == ST_IDLE) ? CRC_INIT : crc_all;

  mbrtu_crc u_crc (
    .crc_in  (crc_seed),
    .data    (item.rx_data),
    .crc_out (crc_new)
  );

  always_comb begin
    link_mode_next      = link_mode;
    gap_count_next      = gap_count;
    gap_running_next    = gap_running;
    rx_count_next       = rx_count;
    crc_all_next        = crc_all;
    crc_less_one_next   = crc_less_one;
    crc_less_two_next   = crc_less_two;
    last_two_bytes_next = last_two_bytes;
    tx_total_next       = tx_total;
    tx_sent_next        = tx_sent;
    tx_on_next          = tx_on;
    result              = '0;
    slen                = item.send_length;
    sent_inc            = (tx_sent < tx_total) ? tx_sent + 9'd1 : tx_sent;

    unique case (item.action)
      ACT_BYTE: begin
        gap_count_next   = '0;
        gap_running_next = 1'b0;
        priority if (link_mode == ST_IDLE) begin
          crc_all_next        = crc_new;
          crc_less_one_next   = CRC_INIT;
          crc_less_two_next   = CRC_INIT;
          last_two_bytes_next = {8'h00, item.rx_data};
          result.store_valid  = 1'b1;
          rx_count_next       = 9'd1;
          gap_count_next      = short_gap;
          gap_running_next    = 1'b1;
          link_mode_next      = ST_RECV;
        end else if (link_mode == ST_RECV) begin
          if (rx_count >= FRAME_BYTES) begin
            rx_count_next    = FRAME_BYTES - 9'd1;
            link_mode_next   = ST_ERR;
            gap_count_next   = long_gap;
            gap_running_next = 1'b1;
          end else begin
            result.store_valid  = 1'b1;
            result.store_index  = rx_count[INDEX_W-1:0];
            crc_less_two_next   = crc_less_one;
            crc_less_one_next   = crc_all;
            crc_all_next        = crc_new;
            last_two_bytes_next = {last_two_bytes[7:0], item.rx_data};
            rx_count_next       = rx_count + 9'd1;
            gap_count_next      = short_gap;
            gap_running_next    = 1'b1;
          end
        end else if (link_mode == ST_GAP) begin
          link_mode_next   = ST_ERR;
          gap_count_next   = long_gap;
          gap_running_next = 1'b1;
        end else begin
          gap_count_next   = long_gap;
          gap_running_next = 1'b1;
        end
      end
      ACT_TICK: begin
        if (gap_running) begin
          if (gap_count > 16'd1) begin
            gap_count_next = gap_count - 16'd1;
          end else begin
            gap_count_next   = '0;
            gap_running_next = 1'b0;
            unique case (link_mode)
              ST_INIT: link_mode_next = ST_IDLE;
              ST_RECV: begin
                link_mode_next   = ST_GAP;
                gap_count_next   = rest_gap;
                gap_running_next = 1'b1;
              end
              ST_GAP:  link_mode_next = ST_READY;
              ST_ERR:  link_mode_next = ST_BAD;
              ST_SEND: begin
                link_mode_next = ST_IDLE;
                tx_on_next     = 1'b0;
              end
              default: link_mode_next = link_mode;
            endcase
          end
        end
      end
      ACT_CHECK: begin
        if (link_mode == ST_BAD || rx_count <= 9'd2) begin
          result.frame_result = RES_BAD;
        end else if ({crc_less_two[7:0], crc_less_two[15:8]} == last_two_bytes) begin
          result.frame_result = RES_GOOD;
        end else begin
          result.frame_result = RES_BAD;
        end
        link_mode_next = ST_IDLE;
      end
      ACT_SEND: begin
        if (link_mode == ST_IDLE) begin
          if (slen == '0) slen = 9'd1;
          if (slen > FRAME_BYTES) slen = FRAME_BYTES;
          tx_total_next        = slen;
          tx_sent_next         = '0;
          tx_on_next           = 1'b1;
          link_mode_next       = ST_SEND;
          result.send_accepted = 1'b1;
          result.send_valid    = 1'b1;
        end
      end
      ACT_SENT: begin
        if (link_mode == ST_SEND) begin
          tx_sent_next = sent_inc;
          if (sent_inc < tx_total) begin
            result.send_valid = 1'b1;
            result.send_index = sent_inc[INDEX_W-1:0];
            gap_count_next    = '0;
            gap_running_next  = 1'b0;
          end else begin
            gap_count_next   = long_gap;
            gap_running_next = 1'b1;
          end
        end else begin
          tx_on_next     = 1'b0;
          link_mode_next = ST_IDLE;
        end
      end
      default: ;
    endcase

    result.link_state   = link_mode_next;
    result.frame_length = rx_count_next;
    result.tx_enable    = tx_on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_gap <= SHORT_GAP_RST;
      rest_gap  <= REST_GAP_RST;
      long_gap  <= LONG_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHORT_GAP: short_gap <= cfg_data;
        CFG_REST_GAP:  rest_gap  <= cfg_data;
        CFG_LONG_GAP:  long_gap  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_mode      <= ST_INIT;
      gap_count      <= LONG_GAP_RST;
      gap_running    <= 1'b1;
      rx_count       <= '0;
      crc_all        <= CRC_INIT;
      crc_less_one   <= CRC_INIT;
      crc_less_two   <= CRC_INIT;
      last_two_bytes <= '0;
      tx_total       <= '0;
      tx_sent        <= '0;
      tx_on          <= 1'b0;
    end else if (fire) begin
      link_mode      <= link_mode_next;
      gap_count      <= gap_count_next;
      gap_running    <= gap_running_next;
      rx_count       <= rx_count_next;
      crc_all        <= crc_all_next;
      crc_less_one   <= crc_less_one_next;
      crc_less_two   <= crc_less_two_next;
      last_two_bytes <= last_two_bytes_next;
      tx_total       <= tx_total_next;
      tx_sent        <= tx_sent_next;
      tx_on          <= tx_on_next;
    end
  end
endmodule

### rtl/modbus_rtu_frame_receiver.sv
// ----------------------------------------------------------------------------
// Modbus RTU frame receiver
// Input register, combinational link update incl. CRC byte step, result register.
// Throughput: one item per cycle unless the result channel is stalled.
// Reset: synchronous; link in init with t3.5 running, gap lengths 750/1000/1750.
// No clearing pass; items are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_receiver (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mbrtu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbrtu_pkg::GAP_W-1:0]     cfg_data,
  mbrtu_cmd_if.sink                       cmd,
  mbrtu_res_if.source                     res
);
  import mbrtu_pkg::*;

  logic    s1_valid;
  item_t   s1_item;
  logic    advance;
  logic    fire;
  logic    res_valid;
  result_t res_data;
  result_t core_result;

  assign advance   = !res_valid || res.ready;
  assign fire      = s1_valid && advance;
  assign cmd.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_item.action      <= cmd.action;
      s1_item.rx_data     <= cmd.rx_data;
      s1_item.send_length <= cmd.send_length;
    end
  end

  mbrtu_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (s1_item),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_data <= core_result;
    end
  end

  assign res.valid         = res_valid;
  assign res.link_state    = res_data.link_state;
  assign res.store_valid   = res_data.store_valid;
  assign res.store_index   = res_data.store_index;
  assign res.frame_result  = res_data.frame_result;
  assign res.frame_length  = res_data.frame_length;
  assign res.send_accepted = res_data.send_accepted;
  assign res.send_valid    = res_data.send_valid;
  assign res.send_index    = res_data.send_index;
  assign res.tx_enable     = res_data.tx_enable;
endmodule

### rtl/mbrtu_checker.sv
// ----------------------------------------------------------------------------
// Modbus RTU frame receiver checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "modbus_rtu_frame_receiver_defines.svh"

module mbrtu_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             res_valid,
  input logic                             res_ready,
  input logic [2:0]                       res_link_state,
  input logic                             res_store_valid,
  input logic [1:0]                       res_frame_result,
  input logic                             res_send_accepted,
  input logic                             res_send_valid,
  input logic [mbrtu_pkg::INDEX_W-1:0]    res_send_index,
  input logic                             res_tx_enable
);
  import mbrtu_pkg::*;

  // stalled result holds
  `MBRTU_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_link_state) && $stable(res_frame_result) && $stable(res_send_index))
  // bytes are stored only while receiving
  `MBRTU_ASSERT_NOW(a_store_recv, clk, rst, res_valid && res_store_valid, res_link_state == ST_RECV)
  // an accepted send starts at byte zero with the driver on
  `MBRTU_ASSERT_NOW(a_send_start, clk, rst, res_valid && res_send_accepted, res_link_state == ST_SEND && res_send_valid && res_send_index == '0 && res_tx_enable)
  // a frame check leaves the link idle
  `MBRTU_ASSERT_NOW(a_check_idle, clk, rst, res_valid && res_frame_result != RES_NONE, res_link_state == ST_IDLE)
endmodule

bind modbus_rtu_frame_receiver mbrtu_checker u_mbrtu_checker (
  .clk               (clk),
  .rst               (rst),
  .res_valid         (res.valid),
  .res_ready         (res.ready),
  .res_link_state    (res.link_state),
  .res_store_valid   (res.store_valid),
  .res_frame_result  (res.frame_result),
  .res_send_accepted (res.send_accepted),
  .res_send_valid    (res.send_valid),
  .res_send_index    (res.send_index),
  .res_tx_enable     (res.tx_enable)
);
